### src/flash_page_record_log_defines.svh
// Assertion macros for the flash page record log checker.
// Needs aclk and aresetn in the scope where a macro is used.
`ifndef FLASH_PAGE_RECORD_LOG_DEFINES_SVH
`define FLASH_PAGE_RECORD_LOG_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define FPRL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define FPRL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/fprl_pkg.sv
// Shared constants, codes and helpers for the flash page record log.
// No dependencies; imported by the top level and its checker.
`default_nettype none

package fprl_pkg;

    localparam int PAGE_BYTES = 4096;
    localparam int WORDS      = PAGE_BYTES / 4;
    localparam int WORD_AW    = $clog2(WORDS);
    localparam int STEP_W     = $clog2(WORDS + 1);

    localparam logic [31:0] PAGE_W     = 32'(PAGE_BYTES);
    localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
    localparam logic [31:0] ALIGN_MASK = 32'hFFFF_FFFC;

    typedef enum logic [1:0] {
        CMD_MOUNT  = 2'd0,
        CMD_BEGIN  = 2'd1,
        CMD_APPEND = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_TOO_LONG  = 2'd1,
        STATUS_BAD_READ  = 2'd2,
        STATUS_NO_RECORD = 2'd3
    } status_t;

    // round up to the next word boundary
    function automatic logic [31:0] align4(input logic [31:0] v);
        return (v + 32'd3) & ALIGN_MASK;
    endfunction

endpackage

`default_nettype wire

### src/flash_page_record_log.sv
// Flash page record log: append-only variable-length records in one erasable page.
// Depends on fprl_pkg and fprl_ram (four byte lanes of PAGE_BYTES/4 words each).
//
//   channel  | ports            | direction | moves
//   ---------+------------------+-----------+---------------------------------
//   s_       | s_valid/s_ready  | in        | one command per transfer
//   m_       | m_valid/m_ready  | out       | one result per command
//   cfg_     | cfg_valid/ready  | in        | page base address write
//
// Append, rejected begin, rejected read and format-on-mount answer straight from idle;
// begin adds a header write (ST_HDR), read adds a byte lane read (ST_READ).
// Mount walks the link chain through the lane read port (ST_WALK), following
// at most PAGE_BYTES/4 links.
// A page erase sweeps the lanes one word per cycle over all PAGE_BYTES/4 words.
// After reset a clearing pass over all PAGE_BYTES/4 words runs with s_ready low.
// A result waiting on m_ready holds s_ready low; cfg_ready is always high.
`default_nettype none

module flash_page_record_log import fprl_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [7:0]  s_data_byte,
    input  logic [12:0] s_record_length,
    input  logic [11:0] s_read_index,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [7:0]  m_read_byte,
    output logic [31:0] m_next_address,
    output logic [31:0] m_last_address,
    output logic [31:0] m_erase_count,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_READ  = 6'b000100,
        ST_WALK  = 6'b001000,
        ST_ERASE = 6'b010000,
        ST_HDR   = 6'b100000
    } state_t;

    localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(WORDS - 1);

    // control state
    state_t              state_reg, state_next;
    logic [31:0]         base_reg, base_next;
    logic [31:0]         next_reg, next_next;
    logic [31:0]         last_reg, last_next;
    logic [31:0]         wp_reg, wp_next;
    logic [12:0]         left_reg, left_next;
    logic [31:0]         count_reg, count_next;
    logic [STEP_W-1:0]   steps_reg, steps_next;
    logic [WORD_AW-1:0]  sweep_reg, sweep_next;
    logic                erase_begin_reg, erase_begin_next;
    logic                m_valid_reg, m_valid_next;

    // payload
    logic [12:0]         len_reg, len_next;
    status_t             status_reg, status_next;
    logic [7:0]          rbyte_reg, rbyte_next;
    logic [1:0]          rd_lo_reg;
    logic [3:0]          rd_ok_reg;

    // byte lanes
    logic [3:0]          lane_we;
    logic [WORD_AW-1:0]  lane_waddr [4];
    logic [7:0]          lane_wdata [4];
    logic [WORD_AW-1:0]  lane_raddr [4];
    logic [7:0]          lane_rdata [4];

    cmd_t                cmd;
    logic                s_fire;
    logic [31:0]         rd_off;
    logic [3:0]          rd_ok;
    logic [7:0]          link_byte [4];
    logic [31:0]         link;
    logic [31:0]         off_next, off_wp, off_last;
    logic [31:0]         len32, end_off, span, rec, clip;
    logic                too_long, overflow, read_hit;

    assign cmd       = cmd_t'(s_command);
    assign s_ready   = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // page offsets of the pointers
    assign off_next = next_reg - base_reg;
    assign off_wp   = wp_reg - base_reg;
    assign off_last = last_reg - base_reg;

    // begin checks
    assign len32    = 32'(s_record_length);
    assign too_long = align4(len32 + 32'd8) >= PAGE_W;
    assign end_off  = align4(off_next + 32'd4 + len32);
    assign overflow = (off_next >= PAGE_W) || (end_off >= PAGE_W);

    // read window of the last record, clipped to the caller size
    assign span     = next_reg - last_reg;
    assign rec      = (span < 32'd4) ? 32'd0 : span - 32'd4;
    assign clip     = (rec > len32) ? len32 : rec;
    assign read_hit = 32'(s_read_index) < clip;

    // bytes of the word read last cycle; bytes outside the page read as erased
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            link_byte[k] = rd_ok_reg[k] ? lane_rdata[2'(rd_lo_reg + 2'(k))] : 8'hFF;
        end
    end
    assign link = {link_byte[3], link_byte[2], link_byte[1], link_byte[0]};

    // read offset: next link while walking, first link on mount, else record byte
    always_comb begin
        priority if (state_reg == ST_WALK) begin
            rd_off = link - base_reg;
        end else if (cmd == CMD_MOUNT) begin
            rd_off = 32'd4;
        end else begin
            rd_off = last_reg + 32'd4 + 32'(s_read_index) - base_reg;
        end
    end

    // per-byte page check and per-lane word address (lanes below the start carry)
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            rd_ok[k] = (rd_off + 32'(k)) < PAGE_W;
        end
        for (int j = 0; j < 4; j++) begin
            lane_raddr[j] = rd_off[WORD_AW+1:2] + WORD_AW'(2'(j) < rd_off[1:0]);
        end
    end

    // main sequencer and lane write port
    always_comb begin
        state_next       = state_reg;
        base_next        = base_reg;
        next_next        = next_reg;
        last_next        = last_reg;
        wp_next          = wp_reg;
        left_next        = left_reg;
        count_next       = count_reg;
        steps_next       = steps_reg;
        sweep_next       = sweep_reg;
        erase_begin_next = erase_begin_reg;
        len_next         = len_reg;
        status_next      = status_reg;
        rbyte_next       = rbyte_reg;
        m_valid_next     = m_valid_reg && !m_ready;

        lane_we = 4'b0000;
        for (int j = 0; j < 4; j++) begin
            lane_waddr[j] = '0;
            lane_wdata[j] = 8'hFF;
        end

        if (cfg_valid) begin
            base_next = cfg_data & ALIGN_MASK;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                lane_we = 4'b1111;
                for (int j = 0; j < 4; j++) begin
                    lane_waddr[j] = sweep_reg;
                end
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST_WORD) begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (s_fire) begin
                    len_next    = s_record_length;
                    status_next = STATUS_OK;
                    rbyte_next  = 8'h00;
                    unique case (cmd)
                        CMD_MOUNT: begin
                            left_next = 13'd0;
                            last_next = base_reg + 32'd4;
                            next_next = base_reg + 32'd4;
                            if (count_reg == ALL_ONES) begin
                                // blank page: format with count one
                                lane_we = 4'b1111;
                                for (int j = 0; j < 4; j++) begin
                                    lane_wdata[j] = 8'(32'd1 >> (8 * j));
                                end
                                count_next   = 32'd1;
                                m_valid_next = 1'b1;
                            end else begin
                                steps_next = '0;
                                state_next = ST_WALK;
                            end
                        end
                        CMD_BEGIN: begin
                            priority if (too_long) begin
                                status_next  = STATUS_TOO_LONG;
                                m_valid_next = 1'b1;
                            end else if (overflow) begin
                                erase_begin_next = 1'b1;
                                sweep_next       = '0;
                                state_next       = ST_ERASE;
                            end else begin
                                last_next  = next_reg;
                                next_next  = base_reg + end_off;
                                wp_next    = next_reg + 32'd4;
                                left_next  = s_record_length;
                                state_next = ST_HDR;
                            end
                        end
                        CMD_APPEND: begin
                            if (left_reg == 13'd0) begin
                                status_next  = STATUS_NO_RECORD;
                                m_valid_next = 1'b1;
                            end else begin
                                if (off_wp < PAGE_W) begin
                                    lane_we[off_wp[1:0]]    = 1'b1;
                                    lane_waddr[off_wp[1:0]] = off_wp[WORD_AW+1:2];
                                    lane_wdata[off_wp[1:0]] = s_data_byte;
                                end
                                // keep the erase counter copy in step with word 0
                                if (off_wp < 32'd4) begin
                                    count_next[{off_wp[1:0], 3'b000} +: 8] = s_data_byte;
                                end
                                wp_next      = wp_reg + 32'd1;
                                left_next    = left_reg - 13'd1;
                                m_valid_next = 1'b1;
                            end
                        end
                        CMD_READ: begin
                            if (read_hit) begin
                                state_next = ST_READ;
                            end else begin
                                status_next  = STATUS_BAD_READ;
                                m_valid_next = 1'b1;
                            end
                        end
                        default: begin
                            m_valid_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_READ: begin
                rbyte_next   = link_byte[0];
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end

            ST_WALK: begin
                priority if (link == ALL_ONES || steps_reg == STEP_W'(WORDS)) begin
                    next_next    = base_reg + align4(off_next);
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end else if (rd_off < PAGE_W) begin
                    // link inside the page: follow it, its read is already issued
                    last_next  = next_reg;
                    next_next  = link;
                    steps_next = steps_reg + 1'b1;
                end else begin
                    erase_begin_next = 1'b0;
                    sweep_next       = '0;
                    state_next       = ST_ERASE;
                end
            end

            ST_ERASE: begin
                lane_we = 4'b1111;
                for (int j = 0; j < 4; j++) begin
                    lane_waddr[j] = sweep_reg;
                    if (sweep_reg == '0) begin
                        lane_wdata[j] = 8'((count_reg + 32'd1) >> (8 * j));
                    end
                end
                if (sweep_reg == '0) begin
                    count_next = count_reg + 32'd1;
                end
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST_WORD) begin
                    if (erase_begin_reg) begin
                        last_next  = base_reg + 32'd4;
                        next_next  = base_reg + align4(32'(len_reg) + 32'd8);
                        wp_next    = base_reg + 32'd8;
                        left_next  = len_reg;
                        state_next = ST_HDR;
                    end else begin
                        last_next    = base_reg + 32'd4;
                        next_next    = base_reg + 32'd4;
                        left_next    = 13'd0;
                        m_valid_next = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
            end

            ST_HDR: begin
                // link word of the new record, aligned and inside the page
                lane_we = 4'b1111;
                for (int j = 0; j < 4; j++) begin
                    lane_waddr[j] = off_last[WORD_AW+1:2];
                    lane_wdata[j] = next_reg[8*j +: 8];
                end
                if (off_last == 32'd0) begin
                    count_next = next_reg;
                end
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            base_reg        <= 32'd0;
            next_reg        <= 32'd4;
            last_reg        <= 32'd4;
            wp_reg          <= 32'd0;
            left_reg        <= 13'd0;
            count_reg       <= ALL_ONES;
            steps_reg       <= '0;
            sweep_reg       <= '0;
            erase_begin_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            base_reg        <= base_next;
            next_reg        <= next_next;
            last_reg        <= last_next;
            wp_reg          <= wp_next;
            left_reg        <= left_next;
            count_reg       <= count_next;
            steps_reg       <= steps_next;
            sweep_reg       <= sweep_next;
            erase_begin_reg <= erase_begin_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg    <= len_next;
        status_reg <= status_next;
        rbyte_reg  <= rbyte_next;
        rd_lo_reg  <= rd_off[1:0];
        rd_ok_reg  <= rd_ok;
    end

    // four byte lanes of the page
    for (genvar g = 0; g < 4; g++) begin : g_lane
        fprl_ram #(
            .WIDTH (8),
            .DEPTH (WORDS)
        ) u_lane (
            .aclk    (aclk),
            .wr_en   (lane_we[g]),
            .wr_addr (lane_waddr[g]),
            .wr_data (lane_wdata[g]),
            .rd_addr (lane_raddr[g]),
            .rd_data (lane_rdata[g])
        );
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_read_byte    = rbyte_reg;
    assign m_next_address = next_reg;
    assign m_last_address = last_reg;
    assign m_erase_count  = count_reg;

endmodule

`default_nettype wire

### src/fprl_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module fprl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### src/flash_page_record_log_checker.sv
// Port-level checks for the flash page record log, bound to the top level.
// Depends on fprl_pkg and flash_page_record_log_defines.svh.
`default_nettype none

`include "flash_page_record_log_defines.svh"

module flash_page_record_log_checker import fprl_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [7:0]  m_read_byte,
    input logic [31:0] m_next_address,
    input logic [31:0] m_last_address,
    input logic [31:0] m_erase_count
);

    logic        stalled;
    logic        failed;
    logic [9:0]  payload;
    logic [95:0] pointers;

    assign stalled  = m_valid && !m_ready;
    assign failed   = m_valid && (m_status != STATUS_OK);
    assign payload  = {m_status, m_read_byte};
    assign pointers = {m_next_address, m_last_address, m_erase_count};

    // a stalled result keeps its status and byte
    `FPRL_ASSERT_NEXT(a_result_held, stalled, m_valid && $stable(payload), "result changed")

    // pointers and counter do not move while a result waits
    `FPRL_ASSERT_NEXT(a_state_held, stalled, $stable(pointers), "pointers moved while stalled")

    // no new command while the previous result is still waiting
    `FPRL_ASSERT_NOW(a_no_accept_stalled, stalled, !s_ready, "command taken while stalled")

    // only a successful read carries a byte
    `FPRL_ASSERT_NOW(a_byte_only_ok, failed, m_read_byte == 8'd0, "byte on a failed result")

endmodule

bind flash_page_record_log flash_page_record_log_checker u_checker (.*);

`default_nettype wire
